>>> rtl/scs_pkg.sv
// Package for the substitution string escape converter.
// Holds the scan modes, the burst and decode types and the byte classifiers.
// No dependencies.
package scs_pkg;

	localparam int unsigned BURST_MAX = 5;
	localparam int unsigned BURST_CW  = $clog2(BURST_MAX + 1);
	localparam logic [15:0] CAP_RESET = 16'd4096;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_U  = 8'h75;
	localparam logic [7:0] CH_UP_U  = 8'h55;
	localparam logic [7:0] CH_LO_L  = 8'h6C;
	localparam logic [7:0] CH_UP_L  = 8'h4C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_ESC      = 3'd1,
		MODE_CASE     = 3'd2,
		MODE_CASE_ESC = 3'd3,
		MODE_DRAIN    = 3'd4
	} scan_mode_t;

	typedef logic [BURST_MAX-1:0][7:0] burst_t;

	typedef struct packed {
		burst_t              bytes;
		logic [BURST_CW-1:0] n;
		scan_mode_t          mode;
		logic [15:0]         count;
	} dec_t;

	function automatic logic is_valid_escape(input logic [7:0] c);
		logic r;
		case (c)
			8'h61, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76,
			8'h28, 8'h29, 8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h2E,
			8'h5C, 8'h7C, 8'h5E, 8'h24, 8'h2A, 8'h2B, 8'h3F,
			8'h26, 8'h22: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// letter for the control bytes that have one, else NUL
	function automatic logic [7:0] control_letter(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h07: r = 8'h61;
			8'h08: r = 8'h62;
			8'h1B: r = 8'h65;
			8'h0C: r = 8'h66;
			8'h0A: r = 8'h6E;
			8'h0D: r = 8'h72;
			8'h09: r = 8'h74;
			8'h0B: r = 8'h76;
			default: r = CH_NUL;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/scs_decode.sv
// Byte decoder: turns one input byte plus scan state into a burst of output
// bytes and the next state. Purely combinational. Depends on scs_pkg.
module scs_decode (
	input  logic [7:0]          c,
	input  scs_pkg::scan_mode_t mode,
	input  logic [15:0]         count,
	input  logic [15:0]         capacity,
	output scs_pkg::dec_t       dec
);
	import scs_pkg::*;

	logic        case_tok;
	logic        keep_esc;
	logic        at_cap;
	logic [7:0]  letter;
	logic        nonprint;
	logic        clr_count;
	logic [16:0] sum;

	assign case_tok = (c == CH_LO_U) || (c == CH_UP_U) || (c == CH_LO_L) || (c == CH_UP_L);
	assign keep_esc = ((c >= CH_ONE) && (c <= CH_NINE)) || is_valid_escape(c);
	assign at_cap   = ({1'b0, count} + 17'd1) >= {1'b0, capacity};
	assign letter   = control_letter(c);
	assign nonprint = (c < CH_SPACE) || (c > CH_TILDE);

	always_comb begin
		dec.bytes = '0;
		dec.n     = '0;
		dec.mode  = MODE_IDLE;
		clr_count = 1'b0;
		case (mode)
			MODE_ESC, MODE_CASE_ESC: begin
				if (mode == MODE_ESC && case_tok) begin
					dec.bytes[0] = CH_BSL;
					dec.bytes[1] = c;
					dec.n        = BURST_CW'(2);
					dec.mode     = MODE_CASE;
				end else if (c == CH_NUL) begin
					// trailing backslash kept literally, then terminator
					dec.bytes[0] = CH_BSL;
					dec.bytes[1] = CH_NUL;
					dec.n        = BURST_CW'(2);
					clr_count    = 1'b1;
				end else if (c == CH_ZERO) begin
					dec.bytes[0] = CH_AMP;
					dec.n        = BURST_CW'(1);
				end else if (keep_esc) begin
					dec.bytes[0] = CH_BSL;
					dec.bytes[1] = c;
					dec.n        = BURST_CW'(2);
				end else begin
					dec.bytes[0] = c;
					dec.n        = BURST_CW'(1);
				end
			end
			MODE_DRAIN: begin
				if (c == CH_NUL) begin
					clr_count = 1'b1;
				end else begin
					dec.mode = MODE_DRAIN;
				end
			end
			default: begin
				// idle and after a case token
				if (c == CH_NUL) begin
					dec.n     = BURST_CW'(1);
					clr_count = 1'b1;
				end else if (c == CH_AMP) begin
					dec.bytes[0] = CH_AMP;
					dec.n        = BURST_CW'(1);
				end else if (c == CH_BSL) begin
					dec.mode = (mode == MODE_CASE) ? MODE_CASE_ESC : MODE_ESC;
				end else if (at_cap) begin
					dec.n    = BURST_CW'(1);
					dec.mode = MODE_DRAIN;
				end else if (letter != CH_NUL) begin
					dec.bytes[0] = CH_BSL;
					dec.bytes[1] = letter;
					dec.n        = BURST_CW'(2);
				end else if (nonprint) begin
					dec.bytes[0] = CH_BSL;
					dec.bytes[1] = CH_ZERO;
					dec.bytes[2] = CH_ZERO + {6'd0, c[7:6]};
					dec.bytes[3] = CH_ZERO + {5'd0, c[5:3]};
					dec.bytes[4] = CH_ZERO + {5'd0, c[2:0]};
					dec.n        = BURST_CW'(5);
				end else begin
					dec.bytes[0] = c;
					dec.n        = BURST_CW'(1);
				end
			end
		endcase

		// saturating count update
		sum = {1'b0, count} + {{(17-BURST_CW){1'b0}}, dec.n};
		if (clr_count) begin
			dec.count = '0;
		end else if (sum[16]) begin
			dec.count = 16'hFFFF;
		end else begin
			dec.count = sum[15:0];
		end
	end

endmodule

>>> rtl/scs_burst.sv
// Output burst register: holds the bytes of one decoded input and hands them
// out one per request, flagging the last. Depends on scs_pkg.
module scs_burst (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  scs_pkg::burst_t              load_bytes,
	input  logic [scs_pkg::BURST_CW-1:0] load_n,
	output logic                         free,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   out_byte,
	output logic                         last_in_run
);
	import scs_pkg::*;

	burst_t              bytes_s2;
	logic [BURST_CW-1:0] rem_q;
	logic                take;

	assign out_valid   = (rem_q != '0);
	assign take        = out_valid && out_ready;
	assign last_in_run = (rem_q == BURST_CW'(1));
	assign free        = !out_valid || (take && last_in_run);
	assign out_byte    = bytes_s2[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= load_n;
		end else if (take) begin
			rem_q <= rem_q - BURST_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= load_bytes;
		end else if (take) begin
			bytes_s2 <= {8'd0, bytes_s2[BURST_MAX-1:1]};
		end
	end

endmodule

>>> rtl/substitution_string_escape_converter.sv
// An accepted input byte is registered in the input stage, then decoded and
// loaded into the burst register, which feeds the single output byte port.
// Bytes causing output (1 to 5) wait for a free burst register, others do not.
// Reset (arst_n low, asynchronous): scan mode idle, count 0, capacity 4096,
// input and output stages empty.
module substitution_string_escape_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_in_run
);
	import scs_pkg::*;

	logic [15:0] capacity_q;
	scan_mode_t  mode_q;
	logic [15:0] count_q;
	logic        valid_s1;
	logic [7:0]  char_s1;
	dec_t        dec;
	logic        burst_free;
	logic        advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	scs_decode u_decode (
		.c        (char_s1),
		.mode     (mode_q),
		.count    (count_q),
		.capacity (capacity_q),
		.dec      (dec)
	);

	// an item with no output bytes never waits for the burst register
	assign advance  = valid_s1 && ((dec.n == '0) || burst_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_IDLE;
			count_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				mode_q  <= dec.mode;
				count_q <= dec.count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	scs_burst u_burst (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && (dec.n != '0)),
		.load_bytes  (dec.bytes),
		.load_n      (dec.n),
		.free        (burst_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_in_run (last_in_run)
	);

endmodule

>>> sim/scs_checker.sv
// Checker for the substitution string escape converter: watches the config, input and
// output channels, predicts each converted byte and compares field by field.
// Depends on scs_pkg for the scan modes and byte constants.
module scs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        last_in_run,
	output int          mismatches,
	output int          pending,
	output int          bytes_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import scs_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} conv_byte_t;

	conv_byte_t  conv_q[$];     // converted bytes still owed by the block
	logic [7:0]  run_bytes[$];  // bytes caused by the current input request
	conv_byte_t  head;
	scan_mode_t  mode;
	logic [15:0] emitted;
	logic [15:0] capacity;

	initial begin
		mismatches = 0;
		pending = 0;
		bytes_checked = 0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 20)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic escape_kept(input logic [7:0] c);
		string keep = "abfnrtv()[]<>.\\|^$*+?&\"";
		for (int i = 0; i < keep.len(); i++)
			if (keep[i] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [7:0] letter_for(input logic [7:0] c);
		case (c)
			8'h07: return "a";
			8'h08: return "b";
			8'h09: return "t";
			8'h0A: return "n";
			8'h0B: return "v";
			8'h0C: return "f";
			8'h0D: return "r";
			8'h1B: return "e";
			default: return CH_NUL;
		endcase
	endfunction

	task automatic emit(input logic [7:0] b);
		run_bytes.push_back(b);
		if (emitted != 16'hFFFF)
			emitted++;
	endtask

	task automatic close_string();
		emit(CH_NUL);
		mode = MODE_IDLE;
		emitted = '0;
	endtask

	task automatic escaped_byte(input logic [7:0] c);
		mode = MODE_IDLE;
		if (c == CH_NUL) begin
			emit(CH_BSL);
			close_string();
		end else if (c == CH_ZERO) begin
			emit(CH_AMP);
		end else if ((c >= CH_ONE && c <= CH_NINE) || escape_kept(c)) begin
			emit(CH_BSL);
			emit(c);
		end else begin
			emit(c);
		end
	endtask

	task automatic plain_char(input logic [7:0] c, input logic after_case);
		logic [7:0] letter;
		letter = letter_for(c);
		mode = MODE_IDLE;
		if (c == CH_NUL) begin
			close_string();
		end else if (c == CH_AMP) begin
			emit(CH_AMP);
		end else if (c == CH_BSL) begin
			mode = after_case ? MODE_CASE_ESC : MODE_ESC;
		end else if ({1'b0, emitted} + 17'd1 >= {1'b0, capacity}) begin
			// destination full: terminate now, swallow the rest of the string
			emit(CH_NUL);
			mode = MODE_DRAIN;
		end else if (letter != CH_NUL) begin
			emit(CH_BSL);
			emit(letter);
		end else if (c < CH_SPACE || c > CH_TILDE) begin
			emit(CH_BSL);
			emit(CH_ZERO);
			emit(CH_ZERO + {6'd0, c[7:6]});
			emit(CH_ZERO + {5'd0, c[5:3]});
			emit(CH_ZERO + {5'd0, c[2:0]});
		end else begin
			emit(c);
		end
	endtask

	task automatic predict_char(input logic [7:0] c);
		run_bytes.delete();
		case (mode)
			MODE_ESC: begin
				if (c == CH_LO_U || c == CH_UP_U || c == CH_LO_L || c == CH_UP_L) begin
					emit(CH_BSL);
					emit(c);
					mode = MODE_CASE;
				end else begin
					escaped_byte(c);
				end
			end
			MODE_CASE: plain_char(c, 1'b1);
			MODE_CASE_ESC: escaped_byte(c);
			MODE_DRAIN: begin
				if (c == CH_NUL) begin
					mode = MODE_IDLE;
					emitted = '0;
				end
			end
			default: plain_char(c, 1'b0);
		endcase
		foreach (run_bytes[i])
			conv_q.push_back('{value: run_bytes[i], last: (i == run_bytes.size() - 1)});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_IDLE;
			emitted = '0;
			capacity = CAP_RESET;
			conv_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			if (in_valid && in_ready)
				predict_char(char_in);
			if (out_valid && out_ready) begin
				if (conv_q.size() == 0) begin
					report_mismatch($sformatf("unexpected output byte %02h", out_byte));
				end else begin
					head = conv_q.pop_front();
					if (out_byte !== head.value)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, head.value));
					if (last_in_run !== head.last)
						report_mismatch($sformatf("last_in_run %b, expected %b (byte %02h)",
							last_in_run, head.last, head.value));
					bytes_checked++;
				end
			end
		end
		pending = conv_q.size();
	end

endmodule

>>> sim/tb.sv
// Top of the escape converter testbench: clock, reset, request stimulus and verdict.
// Instantiates substitution_string_escape_converter and scs_checker; uses scs_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scs_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last_in_run;

	int mismatches;
	int pending;
	int bytes_checked;

	bit steady = 1'b0;    // no idling on either side while set
	int holds_asked = 0;
	int holds_served = 0;
	int sent = 0;
	int cfg_writes = 0;

	string kept_escapes = "abfnrtv()[]<>.\\|^$*+?&\"";
	logic [7:0] case_letters[4] = '{CH_LO_U, CH_UP_U, CH_LO_L, CH_UP_L};

	// plain bytes, every escape form, case tokens and the end-of-string corners
	logic [7:0] opening_bytes[] = '{
		8'h61, CH_AMP, 8'hFF, 8'h01, 8'h1B, 8'h7F, CH_TILDE,
		CH_BSL, CH_ZERO, CH_BSL, CH_NINE, CH_BSL, 8'h2E, CH_BSL, 8'h7A,
		CH_BSL, CH_LO_U, 8'h71, CH_BSL, CH_UP_L, CH_BSL, CH_LO_L, CH_NUL,
		CH_BSL, CH_UP_U, CH_NUL,
		CH_BSL, CH_NUL
	};

	substitution_string_escape_converter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_in     (char_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_in_run (last_in_run)
	);

	scs_checker conv_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_in       (char_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_in_run   (last_in_run),
		.mismatches    (mismatches),
		.pending       (pending),
		.bytes_checked (bytes_checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic push_char(input logic [7:0] c);
		if (!steady && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// wait until every converted byte is out, then cover the pipeline latency
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [15:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	task automatic push_escape();
		logic [7:0] letter;
		push_char(CH_BSL);
		case ($urandom_range(5))
			0: push_char(CH_ZERO);
			1: push_char(8'($urandom_range(57, 49)));
			2: push_char(kept_escapes[$urandom_range(kept_escapes.len() - 1)]);
			3: push_char(8'($urandom()));
			default: begin
				letter = case_letters[$urandom_range(3)];
				push_char(letter);
				case ($urandom_range(2))
					0: begin
						push_char(CH_BSL);
						push_char(case_letters[$urandom_range(3)]);
					end
					1: push_char(CH_NUL);
					default: ;
				endcase
			end
		endcase
	endtask

	task automatic send_string(input int pieces);
		repeat (pieces) begin
			case ($urandom_range(9))
				0, 1, 2: push_char(8'($urandom_range(126, 32)));
				3: push_char(CH_AMP);
				4: push_char($urandom_range(1) ? 8'h1B : 8'($urandom_range(13, 7)));
				5: push_char(8'($urandom_range(255, 1)));
				6, 7, 8: push_escape();
				default: push_char(8'($urandom()));
			endcase
		end
		push_char(CH_NUL);
	endtask

	task automatic run_strings(input int n_items);
		int stop;
		stop = sent + n_items;
		while (sent < stop) begin
			send_string($urandom_range(12, 1));
			// now and then let the block run dry before the next string
			if ($urandom_range(9) == 0)
				settle();
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (holds_asked != holds_served) begin
				out_ready <= 1'b0;
				holds_served++;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 12);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_bytes[i])
			push_char(opening_bytes[i]);

		set_capacity(16'd4096);
		run_strings(60);

		set_capacity(16'd0);
		run_strings(25);

		set_capacity(16'd1);
		run_strings(25);

		// long output stall while input keeps coming
		set_capacity(16'd8);
		holds_asked++;
		run_strings(80);

		// widest capacity, requests back to back on both sides
		set_capacity(16'hFFFF);
		steady = 1'b1;
		run_strings(50);
		steady = 1'b0;

		set_capacity(16'($urandom_range(40, 2)));
		run_strings(70);

		settle();
		repeat (8) @(posedge clk);
		$display("Sent %0d input bytes over %0d capacity settings, checked %0d output bytes",
			sent, cfg_writes, bytes_checked);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
